// ----- src/upd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URI path decoder
// Parser states, status codes, the per-URI context record and the
// character constants that the decoder compares against.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Default width of the internal signed depth counter.
    localparam int DepthBitsDef = 12;
    // Width of the reported depth field.
    localparam int OutDepthW    = 12;

    localparam logic [7:0] ChSlash   = 8'h2F;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChQuest   = 8'h3F;
    localparam logic [7:0] ChCaseBit = 8'h20;
    localparam logic [7:0] ChNul     = 8'h00;

    typedef enum logic [2:0] {
        PS_CONTENT    = 3'd0,
        PS_SLASH      = 3'd1,
        PS_DOT        = 3'd2,
        PS_DOTDOT     = 3'd3,
        PS_QSTART     = 3'd4,
        PS_QCHAR2     = 3'd5,
        PS_QUERYSTART = 3'd6,
        PS_QUERY      = 3'd7
    } t_pstate;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HEX   = 2'd1,
        ST_NUL       = 2'd2,
        ST_UNTERM    = 2'd3
    } t_status;

    // Parser context carried from one byte to the next.
    typedef struct packed {
        t_pstate    pstate;
        t_pstate    rstate;
        logic [3:0] hnib;
        t_status    err;
    } t_ctx;

    localparam t_ctx CtxReset = '{
        pstate: PS_CONTENT,
        rstate: PS_CONTENT,
        hnib:   4'h0,
        err:    ST_OK
    };

    // Step result for one byte, besides the next context.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       query;
        logic       dep_up;
        logic       dep_dn;
    } t_step;

endpackage

// ----- src/upd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_if: request and result channels of the URI path decoder
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] uri_byte;
    logic       is_last;

    modport source (output valid, output uri_byte, output is_last, input ready);
    modport sink   (input valid, input uri_byte, input is_last, output ready);
endinterface

interface upd_out_if;
    logic              valid;
    logic              ready;
    logic              byte_valid;
    logic [7:0]        out_byte;
    logic              in_query;
    logic              done_res;
    logic [1:0]        status;
    logic signed [11:0] depth;
    logic              traversal;

    modport source (
        output valid, output byte_valid, output out_byte, output in_query,
        output done_res, output status, output depth, output traversal,
        input ready
    );
    modport sink (
        input valid, input byte_valid, input out_byte, input in_query,
        input done_res, input status, input depth, input traversal,
        output ready
    );
endinterface

// ----- src/uri_path_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_path_decoder: streaming percent decoder with directory depth tracking
// Decodes request URI bytes, follows dot segments and switches to query bytes.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one raw URI byte per request plus is_last on the final byte
//   of a URI. o_res returns exactly one result per request, in order: an
//   optional decoded path byte or raw query byte, and on the last byte the
//   status, the saturated signed depth and the traversal flag.
// Pipeline and throughput:
//   A request is held in an input register, runs through the parser step and
//   lands in the result register, which drives o_res.valid. One request per
//   cycle is sustained while o_res.ready stays high; the only loop is the
//   parser context update between the step logic and the context registers.
// Reset:
//   i_rst_n (synchronous, active low) empties both registers and returns the
//   parser to content state with depth zero and no error.
// Stall:
//   While o_res.ready is low the result register holds; the input register
//   still takes one more request, then i_req.ready drops until the result
//   moves on. After the last byte of a URI the context resets for the next.
// ----------------------------------------------------------------------------
module uri_path_decoder #(
    parameter int DEPTH_BITS = upd_pkg::DepthBitsDef
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    upd_in_if.sink   i_req,
    upd_out_if.source o_res
);
    import upd_pkg::*;

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parser context, carried across bytes of one URI.
    t_ctx                         r_ctx,   n_ctx;
    logic signed [DEPTH_BITS-1:0] r_depth, n_depth;

    // Result register.
    logic                  r_out_vld;
    logic                  r_byte_valid;
    logic [7:0]            r_out_byte;
    logic                  r_in_query;
    logic                  r_done;
    logic [1:0]            r_status;
    logic signed [OutDepthW-1:0] r_out_depth;
    logic                  r_trav;

    t_step             step;
    logic signed [31:0] depth_ext;
    logic              advance;

    // Advance the input stage whenever the result slot is free or draining.
    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || advance;

    upd_step u_step (
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_step (step)
    );

    upd_depth #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_depth (
        .i_depth (r_depth),
        .i_up    (step.dep_up),
        .i_dn    (step.dep_dn),
        .o_depth (n_depth)
    );

    // Sign-extend or trim the counter to the reported width.
    assign depth_ext = 32'(n_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctx     <= CtxReset;
            r_depth   <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                if (r_in_last) begin
                    // Reset the context for the next URI.
                    r_ctx   <= CtxReset;
                    r_depth <= '0;
                end else begin
                    r_ctx   <= n_ctx;
                    r_depth <= n_depth;
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte <= i_req.uri_byte;
            r_in_last <= i_req.is_last;
        end
        if (advance) begin
            r_byte_valid <= step.emit;
            r_out_byte   <= step.data;
            r_in_query   <= step.query;
            r_done       <= r_in_last;
            r_status     <= r_in_last ? n_ctx.err : ST_OK;
            if (r_in_last && n_ctx.err == ST_OK) begin
                r_out_depth <= depth_ext[OutDepthW-1:0];
                r_trav      <= n_depth[DEPTH_BITS-1];
            end else begin
                r_out_depth <= '0;
                r_trav      <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.byte_valid = r_byte_valid;
    assign o_res.out_byte   = r_out_byte;
    assign o_res.in_query   = r_in_query;
    assign o_res.done_res   = r_done;
    assign o_res.status     = r_status;
    assign o_res.depth      = r_out_depth;
    assign o_res.traversal  = r_trav;
endmodule

// ----- src/upd_depth.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_depth: saturating directory depth update
// Applies +1 or -1 to the signed depth, clamped to the counter's range.
// ----------------------------------------------------------------------------
module upd_depth #(
    parameter int DEPTH_BITS = upd_pkg::DepthBitsDef
) (
    input  logic signed [DEPTH_BITS-1:0] i_depth,
    input  logic                         i_up,
    input  logic                         i_dn,
    output logic signed [DEPTH_BITS-1:0] o_depth
);
    localparam logic signed [DEPTH_BITS-1:0] DepMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DepMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DepOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        o_depth = i_depth;
        if (i_up && i_depth != DepMax) begin
            o_depth = i_depth + DepOne;
        end else if (i_dn && i_depth != DepMin) begin
            o_depth = i_depth - DepOne;
        end
    end
endmodule

// ----- src/upd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_step: per-byte parser step
// Escape decoding, dot-segment tracking and query switch for one byte.
// ----------------------------------------------------------------------------
module upd_step (
    input  logic          [7:0] i_byte,
    input  logic                i_last,
    input  upd_pkg::t_ctx       i_ctx,
    output upd_pkg::t_ctx       o_ctx,
    output upd_pkg::t_step      o_step
);
    import upd_pkg::*;

    // Hex digit value; bit 4 flags a non-hex character.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] l;
        l = c | ChCaseBit;
        hex_val = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            hex_val = {1'b0, 4'(c - 8'h30)};
        end else if (l inside {[8'h61:8'h66]}) begin
            hex_val = {1'b0, 4'(l - 8'h57)};
        end
    endfunction

    logic [4:0] hv;
    logic [7:0] dec;
    logic       do_feed;
    logic [7:0] fb;
    t_pstate    fs;
    t_ctx       nc;
    t_step      st;

    assign hv  = hex_val(i_byte);
    assign dec = {i_ctx.hnib, hv[3:0]};

    always_comb begin
        nc      = i_ctx;
        st      = '0;
        do_feed = 1'b0;
        fb      = i_byte;
        fs      = i_ctx.pstate;

        if (i_ctx.err == ST_OK) begin
            if (i_ctx.pstate == PS_QSTART) begin
                if (hv[4]) begin
                    nc.err = ST_BAD_HEX;
                end else begin
                    nc.hnib   = hv[3:0];
                    nc.pstate = PS_QCHAR2;
                end
            end else if (i_ctx.pstate == PS_QCHAR2) begin
                if (hv[4]) begin
                    nc.err = ST_BAD_HEX;
                end else if (dec == ChNul) begin
                    nc.err = ST_NUL;
                end else if (dec == ChPercent) begin
                    nc.pstate = PS_CONTENT;
                    st.emit   = 1'b1;
                    st.data   = dec;
                end else begin
                    do_feed = 1'b1;
                    fb      = dec;
                    fs      = i_ctx.rstate;
                end
            end else begin
                do_feed = 1'b1;
            end
        end

        if (do_feed) begin
            nc.pstate = fs;
            case (fs)
                PS_CONTENT: begin
                    if (fb == ChSlash) begin
                        nc.pstate = PS_SLASH;
                        st.emit   = 1'b1;
                    end else if (fb == ChPercent) begin
                        nc.rstate = PS_CONTENT;
                        nc.pstate = PS_QSTART;
                    end else if (fb == ChQuest) begin
                        nc.pstate = PS_QUERYSTART;
                    end else begin
                        st.emit = 1'b1;
                    end
                end
                PS_SLASH, PS_DOT: begin
                    if (fb == ChSlash) begin
                        nc.pstate = PS_SLASH;
                        st.emit   = 1'b1;
                    end else if (fb == ChDot) begin
                        nc.pstate = (fs == PS_SLASH) ? PS_DOT : PS_DOTDOT;
                        st.emit   = 1'b1;
                    end else if (fb == ChPercent) begin
                        nc.rstate = fs;
                        nc.pstate = PS_QSTART;
                    end else if (fb == ChQuest) begin
                        nc.pstate = PS_QUERYSTART;
                        st.dep_up = 1'b1;
                    end else begin
                        nc.pstate = PS_CONTENT;
                        st.emit   = 1'b1;
                        st.dep_up = 1'b1;
                    end
                end
                PS_DOTDOT: begin
                    if (fb == ChSlash) begin
                        nc.pstate = PS_SLASH;
                        st.emit   = 1'b1;
                        st.dep_dn = 1'b1;
                    end else if (fb == ChPercent) begin
                        nc.rstate = PS_DOTDOT;
                        nc.pstate = PS_QSTART;
                    end else begin
                        nc.pstate = PS_CONTENT;
                        st.emit   = 1'b1;
                        st.dep_up = 1'b1;
                    end
                end
                PS_QUERYSTART: begin
                    if (fb != ChQuest) begin
                        nc.pstate = PS_QUERY;
                        st.emit   = 1'b1;
                        st.query  = 1'b1;
                    end
                end
                default: begin
                    st.emit  = 1'b1;
                    st.query = 1'b1;
                end
            endcase
            st.data = fb;
        end

        // Escape still open on the final byte.
        if (i_last && nc.err == ST_OK &&
            (nc.pstate == PS_QSTART || nc.pstate == PS_QCHAR2)) begin
            nc.err = ST_UNTERM;
        end

        // Drop all byte output once an error is latched.
        if (nc.err != ST_OK) begin
            st = '0;
        end
        if (!st.emit) begin
            st.data  = 8'h00;
            st.query = 1'b0;
        end
    end

    assign o_ctx  = nc;
    assign o_step = st;
endmodule

// ----- dv/upd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_checker: result checker for the URI path decoder
// Watches both channels, predicts one result per accepted request from its
// own copy of the parser context, and compares every result field by field.
// ----------------------------------------------------------------------------
module upd_checker
    import upd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    upd_in_if    i_req,
    upd_out_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_traversals
);

    typedef struct packed {
        logic                        byte_valid;
        logic [7:0]                  out_byte;
        logic                        in_query;
        logic                        done_res;
        t_status                     status;
        logic signed [OutDepthW-1:0] depth;
        logic                        traversal;
    } t_result;

    // Decoder context as the block should hold it.
    t_pstate cur_state;
    t_pstate resume_state;
    logic [3:0] hi_nib;
    int depth_now;
    t_status err_now;

    // Byte produced by the current request, if any.
    logic em_valid;
    logic [7:0] em_byte;
    logic em_query;

    t_result result_q[$];
    int fail_total;
    int checked_total;
    int waiting;
    int below_root;

    assign o_errors     = fail_total;
    assign o_pending    = waiting;
    assign o_checked    = checked_total;
    assign o_traversals = below_root;

    task automatic clear_context();
        cur_state    = PS_CONTENT;
        resume_state = PS_CONTENT;
        hi_nib       = 4'h0;
        depth_now    = 0;
        err_now      = ST_OK;
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | ChCaseBit;
        if (c >= "0" && c <= "9") return c - "0";
        if (lc >= "a" && lc <= "f") return lc - "a" + 10;
        return -1;
    endfunction

    task automatic shift_depth(input int delta);
        int lim;
        int v;
        lim = 1 << (DepthBitsDef - 1);
        v = depth_now + delta;
        if (v > lim - 1) v = lim - 1;
        if (v < -lim) v = -lim;
        depth_now = v;
    endtask

    task automatic emit(input logic [7:0] c, input logic q);
        em_valid = 1'b1;
        em_byte  = c;
        em_query = q;
    endtask

    // One byte through a state outside an escape.
    task automatic path_char(input logic [7:0] c);
        case (cur_state)
            PS_CONTENT: begin
                if (c == ChSlash) begin
                    cur_state = PS_SLASH;
                    emit(c, 1'b0);
                end else if (c == ChPercent) begin
                    resume_state = PS_CONTENT;
                    cur_state    = PS_QSTART;
                end else if (c == ChQuest) begin
                    cur_state = PS_QUERYSTART;
                end else begin
                    emit(c, 1'b0);
                end
            end
            PS_SLASH, PS_DOT: begin
                if (c == ChSlash) begin
                    cur_state = PS_SLASH;
                    emit(c, 1'b0);
                end else if (c == ChDot) begin
                    cur_state = (cur_state == PS_SLASH) ? PS_DOT : PS_DOTDOT;
                    emit(c, 1'b0);
                end else if (c == ChPercent) begin
                    resume_state = cur_state;
                    cur_state    = PS_QSTART;
                end else if (c == ChQuest) begin
                    cur_state = PS_QUERYSTART;
                    shift_depth(1);
                end else begin
                    cur_state = PS_CONTENT;
                    emit(c, 1'b0);
                    shift_depth(1);
                end
            end
            PS_DOTDOT: begin
                if (c == ChSlash) begin
                    emit(c, 1'b0);
                    shift_depth(-1);
                    cur_state = PS_SLASH;
                end else if (c == ChPercent) begin
                    resume_state = PS_DOTDOT;
                    cur_state    = PS_QSTART;
                end else begin
                    cur_state = PS_CONTENT;
                    emit(c, 1'b0);
                    shift_depth(1);
                end
            end
            PS_QUERYSTART: begin
                if (c != ChQuest) begin
                    cur_state = PS_QUERY;
                    emit(c, 1'b1);
                end
            end
            default: begin
                emit(c, 1'b1);
            end
        endcase
    endtask

    task automatic decode_request(input logic [7:0] c, input logic last,
                                  output t_result r);
        int h;
        logic [7:0] dec;
        em_valid = 1'b0;
        em_byte  = 8'h00;
        em_query = 1'b0;
        if (err_now == ST_OK) begin
            if (cur_state == PS_QSTART) begin
                h = hex_digit(c);
                if (h < 0) begin
                    err_now = ST_BAD_HEX;
                end else begin
                    hi_nib    = h[3:0];
                    cur_state = PS_QCHAR2;
                end
            end else if (cur_state == PS_QCHAR2) begin
                h = hex_digit(c);
                if (h < 0) begin
                    err_now = ST_BAD_HEX;
                end else begin
                    dec = {hi_nib, h[3:0]};
                    if (dec == ChNul) begin
                        err_now = ST_NUL;
                    end else if (dec == ChPercent) begin
                        cur_state = PS_CONTENT;
                        emit(dec, 1'b0);
                    end else begin
                        cur_state = resume_state;
                        path_char(dec);
                    end
                end
            end else begin
                path_char(c);
            end
        end
        if (last && err_now == ST_OK && (cur_state == PS_QSTART || cur_state == PS_QCHAR2))
            err_now = ST_UNTERM;
        r = '0;
        if (err_now == ST_OK) begin
            r.byte_valid = em_valid;
            r.out_byte   = em_byte;
            r.in_query   = em_query;
        end
        r.done_res = last;
        if (last) begin
            r.status = err_now;
            if (err_now == ST_OK) begin
                r.depth     = depth_now[OutDepthW-1:0];
                r.traversal = (depth_now < 0);
            end
            clear_context();
        end
    endtask

    task automatic report(input string field, input logic [15:0] got_v,
                          input logic [15:0] want_v);
        fail_total++;
        if (fail_total <= 40)
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $time, checked_total, field, got_v, want_v);
    endtask

    initial begin
        fail_total    = 0;
        checked_total = 0;
        waiting       = 0;
        below_root    = 0;
        clear_context();
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_context();
            result_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                decode_request(i_req.uri_byte, i_req.is_last, want);
                result_q = {result_q, want};
            end
            if (i_res.valid && i_res.ready) begin
                checked_total++;
                if (result_q.size() == 0) begin
                    report("result with nothing pending, done_res", 16'(i_res.done_res),
                           16'h0000);
                end else begin
                    want = result_q.pop_front();
                    if (want.done_res && want.traversal) below_root++;
                    if (i_res.byte_valid !== want.byte_valid)
                        report("byte_valid", i_res.byte_valid, want.byte_valid);
                    if (i_res.out_byte !== want.out_byte)
                        report("out_byte", i_res.out_byte, want.out_byte);
                    if (i_res.in_query !== want.in_query)
                        report("in_query", i_res.in_query, want.in_query);
                    if (i_res.done_res !== want.done_res)
                        report("done_res", i_res.done_res, want.done_res);
                    if (i_res.status !== want.status)
                        report("status", i_res.status, want.status);
                    if (i_res.depth !== want.depth)
                        report("depth", i_res.depth, want.depth);
                    if (i_res.traversal !== want.traversal)
                        report("traversal", i_res.traversal, want.traversal);
                end
            end
        end
        waiting = result_q.size();
    end

endmodule

// ----- dv/uri_path_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_path_decoder_test: stimulus and verdict for the URI path decoder
// Sends short hand-picked URIs, two longer URIs that climb and sink the depth
// counter, then random URIs built from path tokens, escapes and noise,
// with random gaps on both channels; a separate checker scores every result.
// ----------------------------------------------------------------------------
module uri_path_decoder_test;
    import upd_pkg::*;

    // Watchdog limit on the whole run, kept with a wide margin.
    localparam int CycleLimit  = 100000;
    localparam int RandomItems = 300;
    // Length of the forced receiver stall, long enough to back up the input.
    localparam int HoldCycles  = 40;
    localparam int RunRepeats  = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    upd_in_if  req_ch ();
    upd_out_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int traversals;

    // Shared between the sender and the receiver: no-idle stretches and the
    // request for one long receiver stall.
    bit fast_mode = 1'b0;
    bit hold_ask  = 1'b0;

    int cycle_count = 0;
    int uri_count   = 0;
    int byte_count  = 0;
    logic [7:0] uri_bytes[$];

    uri_path_decoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    upd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_errors     (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_traversals (traversals)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one request. Entered just after a rising edge (or from a falling
    // edge); returns right after the edge that accepted the request. The
    // valid line is only lowered when a gap is drawn, so a back-to-back
    // request never gets two updates in one time step.
    task automatic send_req(input logic [7:0] b, input logic last);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.uri_byte <= b;
        req_ch.is_last  <= last;
        do @(posedge clk); while (!req_ch.ready);
        byte_count++;
    endtask

    task automatic send_text(input string s);
        uri_count++;
        for (int k = 0; k < s.len(); k++) send_req(s[k], k == s.len() - 1);
    endtask

    // Hold the sender until every predicted result has come back. Step to a
    // falling edge first so the checker has seen the last acceptance.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 10) c = 8'("0" + n);
        else c = 8'("a" + n - 10);
        // Mix upper and lower case for the letter digits.
        if (n >= 10 && $urandom_range(0, 1)) c = c & ~ChCaseBit;
        return c;
    endfunction

    // Decoded values worth hitting: the structural characters, the escape
    // character itself, the rare NUL and anything else.
    function automatic logic [7:0] escape_target();
        case ($urandom_range(0, 7))
            0: return ChSlash;
            1: return ChDot;
            2: return ChPercent;
            3: return ChQuest;
            4: return ($urandom_range(0, 3) == 0) ? ChNul : ChDot;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Append one byte to the URI under construction.
    task automatic add_byte(input logic [7:0] b);
        uri_bytes = {uri_bytes, b};
    endtask

    task automatic push_escape(input logic [7:0] v);
        add_byte(ChPercent);
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endtask

    // Build one random URI into uri_bytes. Most are path-shaped token runs;
    // some are raw noise, and some carry broken or truncated escapes.
    task automatic build_uri();
        string bad_digits;
        int tokens;
        int pick;
        bad_digits = "gGzZ/.%? -";
        uri_bytes = {};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 7) != 0) add_byte(ChSlash);
        tokens = $urandom_range(1, 10);
        repeat (tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                add_byte(ChSlash);
            end else if (pick < 32) begin
                add_byte(ChDot);
            end else if (pick < 44) begin
                add_byte(ChSlash);
                add_byte(ChDot);
                add_byte(ChDot);
            end else if (pick < 60) begin
                repeat ($urandom_range(1, 3)) add_byte(8'("a" + $urandom_range(0, 25)));
            end else if (pick < 76) begin
                push_escape(escape_target());
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 2)) add_byte(ChQuest);
            end else if (pick < 94) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                // Broken escape: bad first digit, or good first and bad second.
                add_byte(ChPercent);
                if ($urandom_range(0, 1)) add_byte(hex_char(4'($urandom_range(0, 15))));
                add_byte(bad_digits[$urandom_range(0, bad_digits.len() - 1)]);
            end
        end
        // Occasionally leave an escape open at the end.
        if ($urandom_range(0, 11) == 0) begin
            add_byte(ChPercent);
            if ($urandom_range(0, 1)) add_byte(hex_char(4'($urandom_range(0, 15))));
        end
    endtask

    // Result side: draw a stall per result, honor one long hold-off on
    // request, then wait for the next result to be taken.
    initial begin : receiver
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            stall = fast_mode ? 0 : $urandom_range(0, 4);
            if (hold_ask) begin
                stall = HoldCycles;
                hold_ask = 1'b0;
            end
            if (stall > 0) begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        int rand_sent;
        req_ch.valid    = 1'b0;
        req_ch.uri_byte = 8'h00;
        req_ch.is_last  = 1'b0;
        rand_sent       = 0;

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed URIs.
        // Dot segments, escapes decoded through the slash and dotdot states,
        // a run of query marks and a raw escape inside the query; the query
        // mark after the decoded slash brings the depth back to the root.
        send_text("/a/../%2e.%2F??%00");
        // Dotdot then a query mark: the mark is a plain path byte.
        send_text("/..?");
        // Single dot then a query mark: counts a level, then query output.
        send_text("/.?x");
        // Bad second hex digit, then bytes that must produce nothing.
        send_text("%4g/a");
        // Bad first hex digit.
        send_text("/%zz");
        // Decoded NUL.
        send_text("/%00b");
        // Escapes left open at the end, after the first digit and right
        // after the percent sign.
        send_text("/%A");
        send_text("%");
        // Raw byte extremes, a decoded percent sign and a trailing single dot.
        uri_count++;
        send_req(8'hFF, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(ChPercent, 1'b0);
        send_req("2", 1'b0);
        send_req("5", 1'b0);
        send_req(ChSlash, 1'b0);
        send_req(ChDot, 1'b1);
        // Trailing slash and trailing dotdot.
        send_text("/");
        send_text("/b/..");
        drain();

        // Climb many levels, then sink well below the root, with no idling.
        fast_mode = 1'b1;
        uri_count++;
        for (int k = 0; k < RunRepeats; k++) begin
            send_req(ChSlash, 1'b0);
            send_req("a", k == RunRepeats - 1);
        end
        uri_count++;
        send_req(ChSlash, 1'b0);
        for (int k = 0; k < RunRepeats; k++) begin
            send_req(ChDot, 1'b0);
            send_req(ChDot, 1'b0);
            send_req(ChSlash, k == RunRepeats - 1);
        end
        fast_mode = 1'b0;
        drain();

        // Random URIs. Ask for the long receiver stall early on while the
        // sender keeps going, and pause for a full drain further in.
        while (rand_sent < RandomItems) begin
            if (uri_count == 20) hold_ask = 1'b1;
            if (uri_count == 32) drain();
            fast_mode = ($urandom_range(0, 4) == 0);
            build_uri();
            uri_count++;
            foreach (uri_bytes[k]) send_req(uri_bytes[k], k == uri_bytes.size() - 1);
            rand_sent += uri_bytes.size();
        end
        fast_mode = 1'b0;

        // Wait for the tail, then keep watching the result channel in case a stray
        // result shows up.
        drain();
        repeat (8) @(negedge clk);

        $display("Covered %0d URIs in %0d request bytes, with deep climbs and sinks.",
                 uri_count, byte_count);
        $display("Checked %0d results; %0d URIs ended below the root.", checked, traversals);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
